// ----- rtl/rfwh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfwh_pkg: shared types and constants of the ring FIFO with history
// Operation codes, field widths and the packing of the stream data words.
// ----------------------------------------------------------------------------
package rfwh_pkg;

	// Operation carried in the low bits of an input transfer
	typedef enum logic [2:0] {
		OP_WR_STEREO = 3'd0,
		OP_WR_MONO   = 3'd1,
		OP_READ      = 3'd2,
		OP_READ_HIST = 3'd3,
		OP_RESTART   = 3'd4
	} op_t;

	localparam int OP_W      = 3;
	localparam int WORD_W    = 32;
	localparam int MONO_W    = 16;
	localparam int COUNT_W   = 15;
	localparam int SIZE_W    = 4;

	// Size register value after reset
	localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd15;

	// Input data word: operation, then sample, padded to whole bytes
	localparam int S_TDATA_W  = 40;
	localparam int S_OP_LSB   = 0;
	localparam int S_SMP_LSB  = S_OP_LSB + OP_W;

	// Output data word: data, accepted, used, free, history, written total
	localparam int M_TDATA_W  = 112;
	localparam int M_DATA_LSB = 0;
	localparam int M_ACC_LSB  = M_DATA_LSB + WORD_W;
	localparam int M_USED_LSB = M_ACC_LSB + 1;
	localparam int M_FREE_LSB = M_USED_LSB + COUNT_W;
	localparam int M_HIST_LSB = M_FREE_LSB + COUNT_W;
	localparam int M_WTOT_LSB = M_HIST_LSB + COUNT_W;
	localparam int M_PAD_LSB  = M_WTOT_LSB + WORD_W;

endpackage

// ----- rtl/rfwh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfwh_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module rfwh_ram #(
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 15
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	localparam int Depth = 2 ** ADDR_W;

	logic [WIDTH-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/ring_fifo_with_history_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_with_history_top: audio ring buffer with look-back history
// Ring of 32-bit words with write, read and trailing history pointers.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one operation (write stereo, write
//   mono, read, read history, restart). Each one yields exactly one transfer
//   on the m_axis channel with the word read (zero if none), an accepted flag,
//   the used / free / history counts after the operation and the running
//   total of written words.
//   Throughput: one operation per cycle while s_axis_tready is high. Pointer
//   updates and the RAM access happen in the accept cycle; the RAM read
//   register and then the result register follow, which drives m_axis.
//   The result register and the stage before it let the input keep moving
//   while a result waits; when m_axis_tready stays low, both stages fill and
//   s_axis_tready drops until the receiver takes a result.
//   cfg_we writes size_log2; it takes effect at the next restart operation.
//   Reset clears the pointers and the written total and loads
//   size_log2 = 15 (clamped to the RAM depth). The ring RAM is not cleared;
//   the pointer rules never read an entry that was not written.
//   Writes are refused when the write pointer would reach the history
//   pointer; reads are refused when nothing is unread (or no history left).
// ----------------------------------------------------------------------------
module ring_fifo_with_history_top #(
	parameter int DEPTH_LOG2 = 15,
	parameter int BAK_MAX    = 16384
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [2:0] operation, [34:3] sample, [39:35] zero
	input  logic [rfwh_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [31:0] data, [32] accepted, [47:33] used_count, [62:48] free_count,
	// [77:63] history_count, [109:78] written_total, [111:110] zero
	output logic [rfwh_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// configuration
	input  logic                           cfg_we,
	input  logic [rfwh_pkg::SIZE_W-1:0]    cfg_wdata
);

	localparam int WordW  = rfwh_pkg::WORD_W;
	localparam int CntW   = rfwh_pkg::COUNT_W;
	localparam int MonoW  = rfwh_pkg::MONO_W;
	localparam int OpW    = rfwh_pkg::OP_W;
	localparam int SizeW  = rfwh_pkg::SIZE_W;
	localparam int PadW   = rfwh_pkg::M_TDATA_W - rfwh_pkg::M_PAD_LSB;
	// Pointer state after reset: size_log2 = 15 clamped to the RAM depth
	localparam int RstLog2  = (15 > DEPTH_LOG2) ? DEPTH_LOG2 : 15;
	localparam int RstHalf  = 2 ** (RstLog2 - 1);
	localparam int LimitCap = (BAK_MAX < 2 ** (DEPTH_LOG2 - 1)) ? BAK_MAX
	                                                            : 2 ** (DEPTH_LOG2 - 1);
	localparam int RstLimit = (RstHalf > LimitCap) ? LimitCap : RstHalf;
	localparam logic [DEPTH_LOG2-1:0] RST_MASK  = DEPTH_LOG2'((2 ** RstLog2) - 1);
	localparam logic [DEPTH_LOG2-1:0] RST_LIMIT = DEPTH_LOG2'(RstLimit);
	localparam logic [DEPTH_LOG2-1:0] LIMIT_CAP = DEPTH_LOG2'(LimitCap);

	typedef logic [DEPTH_LOG2-1:0] ptr_t;

	// Result fields that do not come from the RAM
	typedef struct packed {
		logic             rd;
		logic             acc;
		logic [CntW-1:0]  used;
		logic [CntW-1:0]  free;
		logic [CntW-1:0]  hist;
		logic [WordW-1:0] wtot;
	} res_meta_t;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	logic [SizeW-1:0] size_q;
	ptr_t             mask_q;
	ptr_t             limit_q;
	ptr_t             wp_q, rp_q, hp_q;
	logic [WordW-1:0] wtot_q;

	res_meta_t        meta_s1;
	logic             v_s1;
	res_meta_t        meta_s2;
	logic [WordW-1:0] data_s2;
	logic             v_s2;

	// ------------------------------------------------------------------
	// Handshake: the two result stages move as a short queue
	// ------------------------------------------------------------------
	logic adv_s2, adv_s1, accept;

	assign adv_s2        = !v_s2 || m_axis_tready;
	assign adv_s1        = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign accept        = s_axis_tvalid && adv_s1;

	// ------------------------------------------------------------------
	// Operation decode and pointer update
	// ------------------------------------------------------------------
	rfwh_pkg::op_t    op;
	logic [WordW-1:0] smp;
	logic [MonoW-1:0] mono;
	logic [WordW-1:0] wr_word;
	ptr_t             used_c, free_c, hist_c;
	logic             wr_ok, rd_ok, hr_ok, rs_ok;
	ptr_t             rp_inc, back_c;
	ptr_t             wp_n, rp_n, hp_n, mask_n, limit_n;
	logic [WordW-1:0] wtot_n;
	// restart view of the size register
	logic [4:0]       cfg_log2;
	ptr_t             cfg_mask, cfg_half, cfg_limit;

	assign op      = rfwh_pkg::op_t'(s_axis_tdata[rfwh_pkg::S_OP_LSB +: OpW]);
	assign smp     = s_axis_tdata[rfwh_pkg::S_SMP_LSB +: WordW];
	assign mono    = smp[MonoW-1:0];
	assign wr_word = (op == rfwh_pkg::OP_WR_MONO) ? {mono, mono} : smp;

	assign used_c = (wp_q - rp_q) & mask_q;
	assign free_c = (hp_q - wp_q - ptr_t'(1)) & mask_q;
	assign hist_c = (rp_q - hp_q) & mask_q;

	// clamp size_log2 into 1..DEPTH_LOG2
	always_comb begin
		if (size_q == '0) begin
			cfg_log2 = 5'd1;
		end else if (5'(size_q) > 5'(DEPTH_LOG2)) begin
			cfg_log2 = 5'(DEPTH_LOG2);
		end else begin
			cfg_log2 = 5'(size_q);
		end
	end

	assign cfg_mask  = ~({DEPTH_LOG2{1'b1}} << cfg_log2);
	assign cfg_half  = (cfg_mask >> 1) + ptr_t'(1);
	assign cfg_limit = (cfg_half > LIMIT_CAP) ? LIMIT_CAP : cfg_half;

	always_comb begin
		wr_ok = 1'b0;
		rd_ok = 1'b0;
		hr_ok = 1'b0;
		rs_ok = 1'b0;
		case (op)
			rfwh_pkg::OP_WR_STEREO, rfwh_pkg::OP_WR_MONO: wr_ok = accept && (free_c != '0);
			rfwh_pkg::OP_READ:      rd_ok = accept && (used_c != '0);
			rfwh_pkg::OP_READ_HIST: hr_ok = accept && (hist_c != '0);
			rfwh_pkg::OP_RESTART:   rs_ok = accept;
			default: ;
		endcase
	end

	// after a read, pull history up so it trails by at most the limit
	assign rp_inc = (rp_q + ptr_t'(1)) & mask_q;
	assign back_c = (rp_inc - hp_q) & mask_q;

	always_comb begin
		wp_n    = wp_q;
		rp_n    = rp_q;
		hp_n    = hp_q;
		mask_n  = mask_q;
		limit_n = limit_q;
		wtot_n  = wtot_q;
		if (wr_ok) begin
			wp_n   = (wp_q + ptr_t'(1)) & mask_q;
			wtot_n = wtot_q + WordW'(1);
		end
		if (rd_ok) begin
			rp_n = rp_inc;
			if (back_c > limit_q) begin
				hp_n = (rp_inc - limit_q) & mask_q;
			end
		end
		if (hr_ok) begin
			hp_n = (hp_q + ptr_t'(1)) & mask_q;
		end
		if (rs_ok) begin
			wp_n    = '0;
			rp_n    = '0;
			hp_n    = '0;
			mask_n  = cfg_mask;
			limit_n = cfg_limit;
		end
	end

	res_meta_t meta_c;

	always_comb begin
		meta_c.rd   = rd_ok || hr_ok;
		meta_c.acc  = wr_ok || rd_ok || hr_ok;
		meta_c.used = CntW'((wp_n - rp_n) & mask_n);
		meta_c.free = CntW'((hp_n - wp_n - ptr_t'(1)) & mask_n);
		meta_c.hist = CntW'((rp_n - hp_n) & mask_n);
		meta_c.wtot = wtot_n;
	end

	// ------------------------------------------------------------------
	// Ring RAM: read data is valid alongside stage 1 and held while stalled
	// ------------------------------------------------------------------
	logic [WordW-1:0] ram_rdata;

	rfwh_ram #(
		.WIDTH  (WordW),
		.ADDR_W (DEPTH_LOG2)
	) u_ram (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (wp_q),
		.wdata (wr_word),
		.re    (rd_ok || hr_ok),
		.raddr (rd_ok ? rp_q : hp_q),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= rfwh_pkg::SIZE_LOG2_RST;
			mask_q  <= RST_MASK;
			limit_q <= RST_LIMIT;
			wp_q    <= '0;
			rp_q    <= '0;
			hp_q    <= '0;
			wtot_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			wp_q    <= wp_n;
			rp_q    <= rp_n;
			hp_q    <= hp_n;
			mask_q  <= mask_n;
			limit_q <= limit_n;
			wtot_q  <= wtot_n;
			if (adv_s1) begin
				v_s1 <= accept;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_c;
		end
		if (adv_s2 && v_s1) begin
			meta_s2 <= meta_s1;
			data_s2 <= meta_s1.rd ? ram_rdata : '0;
		end
	end

	// ------------------------------------------------------------------
	// Output packing
	// ------------------------------------------------------------------
	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {PadW'(0), meta_s2.wtot, meta_s2.hist, meta_s2.free,
	                        meta_s2.used, meta_s2.acc, data_s2};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// pointers never leave the active ring size
	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		((wp_q & ~mask_q) == '0) && ((rp_q & ~mask_q) == '0) && ((hp_q & ~mask_q) == '0))
		else $error("pointer outside active ring");

	// history never trails the read pointer by more than the limit
	a_hist_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hist_c <= limit_q)
		else $error("history window exceeds limit");

	// a RAM write never overruns the history pointer
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ok |-> (free_c != '0) && s_axis_tvalid && s_axis_tready)
		else $error("write into full ring");

	// the written total moves only after an accepted write
	a_wtot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wtot_q != $past(wtot_q)) |-> $past(wr_ok))
		else $error("written total changed without a write");

	// a result holds while the receiver stalls
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the ring FIFO with look-back history
// Drives operations on the input stream and keeps a shadow ring in the
// testbench. Each result transfer is checked field by field against the
// shadow ring. Directed tests come first, then random phases at several
// ring sizes, most with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;

	localparam int RING_LOG2 = 15;
	localparam int HIST_CAP  = 16384;

	logic                              clk;
	logic                              arst_n;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [rfwh_pkg::S_TDATA_W-1:0]    s_axis_tdata;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [rfwh_pkg::M_TDATA_W-1:0]    m_axis_tdata;
	logic                              cfg_we;
	logic [rfwh_pkg::SIZE_W-1:0]       cfg_wdata;

	// One result transfer, unpacked
	typedef struct {
		logic [rfwh_pkg::WORD_W-1:0]  data;
		logic                         accepted;
		logic [rfwh_pkg::COUNT_W-1:0] used_words;
		logic [rfwh_pkg::COUNT_W-1:0] free_words;
		logic [rfwh_pkg::COUNT_W-1:0] hist_words;
		logic [rfwh_pkg::WORD_W-1:0]  total_written;
	} ring_result_t;

	ring_result_t pending_results[$];

	// Shadow ring state
	logic [rfwh_pkg::WORD_W-1:0] ring_copy [0:(1<<RING_LOG2)-1];
	bit [31:0]                   rd_ptr;
	bit [31:0]                   wr_ptr;
	bit [31:0]                   hist_ptr;
	bit [31:0]                   samples_written;
	bit [rfwh_pkg::SIZE_W-1:0]   size_log2_reg;
	int                          active_log2;

	int mismatch_count;
	int result_index;
	int stall_left;
	bit src_idle_on;
	bit sink_idle_on;

	ring_fifo_with_history_top #(
		.DEPTH_LOG2(RING_LOG2),
		.BAK_MAX   (HIST_CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("tb: mismatch: %s", msg);
	endtask

	function automatic int clamp_size(input int v);
		if (v < 1)
			return 1;
		if (v > RING_LOG2)
			return RING_LOG2;
		return v;
	endfunction

	// Apply one operation to the shadow ring and return the result it gives
	function automatic ring_result_t step_ring(input logic [rfwh_pkg::OP_W-1:0] op,
			input logic [rfwh_pkg::WORD_W-1:0] smp);
		bit [31:0] m;
		bit [31:0] used;
		bit [31:0] freew;
		bit [31:0] hv;
		bit [31:0] lim;
		bit [31:0] back;
		ring_result_t r;
		m = (32'd1 << active_log2) - 32'd1;
		used = (wr_ptr - rd_ptr) & m;
		freew = (hist_ptr - wr_ptr + m) & m;
		hv = (rd_ptr - hist_ptr) & m;
		r.data = '0;
		r.accepted = 1'b0;
		case (op)
			rfwh_pkg::OP_WR_STEREO, rfwh_pkg::OP_WR_MONO: begin
				if (freew != 0) begin
					ring_copy[wr_ptr[RING_LOG2-1:0]] = (op == rfwh_pkg::OP_WR_MONO) ?
						{smp[rfwh_pkg::MONO_W-1:0], smp[rfwh_pkg::MONO_W-1:0]} : smp;
					wr_ptr = (wr_ptr + 1) & m;
					samples_written = samples_written + 1;
					r.accepted = 1'b1;
				end
			end
			rfwh_pkg::OP_READ: begin
				if (used != 0) begin
					lim = (m + 1) >> 1;
					if (lim > HIST_CAP)
						lim = HIST_CAP;
					r.data = ring_copy[rd_ptr[RING_LOG2-1:0]];
					rd_ptr = (rd_ptr + 1) & m;
					// push the history pointer so it trails by at most the limit
					back = (rd_ptr - hist_ptr) & m;
					if (back > lim)
						hist_ptr = (hist_ptr + (back - lim)) & m;
					r.accepted = 1'b1;
				end
			end
			rfwh_pkg::OP_READ_HIST: begin
				if (hv != 0) begin
					r.data = ring_copy[hist_ptr[RING_LOG2-1:0]];
					hist_ptr = (hist_ptr + 1) & m;
					r.accepted = 1'b1;
				end
			end
			rfwh_pkg::OP_RESTART: begin
				rd_ptr = 0;
				wr_ptr = 0;
				hist_ptr = 0;
				active_log2 = clamp_size(int'(size_log2_reg));
				m = (32'd1 << active_log2) - 32'd1;
			end
			default: ;
		endcase
		r.used_words = rfwh_pkg::COUNT_W'((wr_ptr - rd_ptr) & m);
		r.free_words = rfwh_pkg::COUNT_W'((hist_ptr - wr_ptr + m) & m);
		r.hist_words = rfwh_pkg::COUNT_W'((rd_ptr - hist_ptr) & m);
		r.total_written = samples_written;
		return r;
	endfunction

	// Send one operation; hold it until the transfer, then record its result
	task automatic send_item(input logic [rfwh_pkg::OP_W-1:0] op,
			input logic [rfwh_pkg::WORD_W-1:0] smp);
		logic [rfwh_pkg::S_TDATA_W-1:0] word;
		word = '0;
		word[rfwh_pkg::S_OP_LSB +: rfwh_pkg::OP_W] = op;
		word[rfwh_pkg::S_SMP_LSB +: rfwh_pkg::WORD_W] = smp;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(step_ring(op, smp));
	endtask

	// Drop valid and wait until every pending result has arrived
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_size(input logic [rfwh_pkg::SIZE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_log2_reg = v;
	endtask

	// Receiver: random stall bursts while enabled
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [rfwh_pkg::WORD_W-1:0] got,
			input logic [rfwh_pkg::WORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %h, expected %h",
				result_index, name, got, want));
	endtask

	// Compare each result transfer with the oldest pending result
	always @(posedge clk) begin : result_check
		ring_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d with no operation pending",
					result_index));
			end else begin
				want = pending_results.pop_front();
				check_field("data",
					m_axis_tdata[rfwh_pkg::M_DATA_LSB +: rfwh_pkg::WORD_W], want.data);
				check_field("accepted",
					rfwh_pkg::WORD_W'(m_axis_tdata[rfwh_pkg::M_ACC_LSB]),
					rfwh_pkg::WORD_W'(want.accepted));
				check_field("used_count",
					rfwh_pkg::WORD_W'(m_axis_tdata[rfwh_pkg::M_USED_LSB +: rfwh_pkg::COUNT_W]),
					rfwh_pkg::WORD_W'(want.used_words));
				check_field("free_count",
					rfwh_pkg::WORD_W'(m_axis_tdata[rfwh_pkg::M_FREE_LSB +: rfwh_pkg::COUNT_W]),
					rfwh_pkg::WORD_W'(want.free_words));
				check_field("history_count",
					rfwh_pkg::WORD_W'(m_axis_tdata[rfwh_pkg::M_HIST_LSB +: rfwh_pkg::COUNT_W]),
					rfwh_pkg::WORD_W'(want.hist_words));
				check_field("written_total",
					m_axis_tdata[rfwh_pkg::M_WTOT_LSB +: rfwh_pkg::WORD_W],
					want.total_written);
			end
			result_index++;
		end
	end

	// Full-size ring after reset: empty reads, extreme words, mono packing,
	// history reads, unknown codes and a restart
	task automatic test_reset_defaults();
		send_item(rfwh_pkg::OP_READ, 32'h1234_5678);
		send_item(rfwh_pkg::OP_READ_HIST, 32'h0);
		send_item(rfwh_pkg::OP_WR_STEREO, 32'h0000_0000);
		send_item(rfwh_pkg::OP_WR_STEREO, 32'hFFFF_FFFF);
		send_item(rfwh_pkg::OP_WR_MONO, 32'h0000_FFFF);
		send_item(rfwh_pkg::OP_WR_MONO, 32'hFFFF_0000);
		send_item(rfwh_pkg::OP_WR_MONO, 32'hABCD_1234);
		send_item(rfwh_pkg::OP_READ, 32'h0);
		send_item(rfwh_pkg::OP_READ, 32'hFFFF_FFFF);
		send_item(rfwh_pkg::OP_READ, 32'h0);
		send_item(rfwh_pkg::OP_READ_HIST, 32'h0);
		send_item(rfwh_pkg::OP_READ_HIST, 32'h0);
		send_item(3'd5, $urandom);
		send_item(3'd6, $urandom);
		send_item(3'd7, $urandom);
		send_item(rfwh_pkg::OP_RESTART, 32'hFFFF_FFFF);
	endtask

	// Size zero clamps to a two-word ring; the new size waits for a restart.
	// One word of history blocks the second write until it is read back.
	task automatic test_smallest_ring();
		drain_results();
		write_size(4'd0);
		send_item(rfwh_pkg::OP_WR_STEREO, 32'hDEAD_BEEF);
		send_item(rfwh_pkg::OP_RESTART, 32'h0);
		send_item(rfwh_pkg::OP_WR_STEREO, 32'h8000_0001);
		send_item(rfwh_pkg::OP_WR_MONO, 32'h0000_7FFF);
		send_item(rfwh_pkg::OP_READ, 32'h0);
		send_item(rfwh_pkg::OP_WR_STEREO, 32'h5555_AAAA);
		send_item(rfwh_pkg::OP_READ_HIST, 32'h0);
		send_item(rfwh_pkg::OP_WR_MONO, 32'h0000_8001);
		send_item(rfwh_pkg::OP_READ, 32'h0);
	endtask

	// One random phase: set the size while idle, optionally latch it at once,
	// then a mix whose write share shifts every few dozen transfers
	task automatic run_random_phase(input logic [rfwh_pkg::SIZE_W-1:0] size, input int n,
			input bit idle_on, input bit restart_first);
		int wbias;
		int r;
		drain_results();
		src_idle_on = idle_on && ($urandom_range(0, 3) != 0);
		sink_idle_on = idle_on && ($urandom_range(0, 3) != 0);
		write_size(size);
		if (restart_first)
			send_item(rfwh_pkg::OP_RESTART, $urandom);
		wbias = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				wbias = $urandom_range(10, 90);
			r = $urandom_range(0, 99);
			if (r < 2)
				send_item(rfwh_pkg::OP_RESTART, $urandom);
			else if (r < 4)
				send_item(3'($urandom_range(5, 7)), $urandom);
			else if ($urandom_range(0, 99) < wbias)
				send_item($urandom_range(0, 1) ? rfwh_pkg::OP_WR_MONO
					: rfwh_pkg::OP_WR_STEREO, $urandom);
			else if ($urandom_range(0, 9) < 7)
				send_item(rfwh_pkg::OP_READ, $urandom);
			else
				send_item(rfwh_pkg::OP_READ_HIST, $urandom);
		end
	endtask

	task automatic test_random_phases();
		logic [rfwh_pkg::SIZE_W-1:0] sizes [10];
		sizes = '{4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd15, 4'd5, 4'd2, 4'd3, 4'd6};
		// the last two phases run without idling on either side
		for (int p = 0; p < 10; p++)
			run_random_phase(sizes[p], 140, p < 8, (p % 3) != 2);
	endtask

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		mismatch_count = 0;
		result_index = 0;
		rd_ptr = 0;
		wr_ptr = 0;
		hist_ptr = 0;
		samples_written = 0;
		size_log2_reg = rfwh_pkg::SIZE_LOG2_RST;
		active_log2 = clamp_size(int'(rfwh_pkg::SIZE_LOG2_RST));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_smallest_ring();
		test_random_phases();

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
